// ----- hdl/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the particle probe pressure block.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 31;

  localparam logic [CFG_AW-1:0] CFG_METHOD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RADIUS = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MIN_NB = 2'd2;

  localparam logic [1:0]  METHOD_RST = 2'd2;
  localparam logic [30:0] RADIUS_RST = 31'd335544;
  localparam logic [10:0] MIN_NB_RST = 11'd3;

  localparam logic [1:0] METHOD_AVG  = 2'd0;
  localparam logic [1:0] METHOD_NEAR = 2'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PROBE = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_ANCHOR = 2'd2;

  typedef enum logic {UM_DIV, UM_SQRT} umode_t;

  typedef struct packed {
    logic   start;
    umode_t mode;
  } ureq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } uresp_t;

  typedef enum logic [1:0] {MQ_W, MQ_X, MQ_Y} mq_ret_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RSQ, S_RSQ_W, S_RD, S_DIFF, S_SQX, S_SQY, S_DSUM, S_EVAL,
    S_W_SQRT, S_W_DIV, S_MQ_MUL, S_MQ_ACC, S_MQ_END, S_W_ACC,
    S_DOT_X, S_DOT_Y, S_DOT_SUM, S_FRAC, S_C, S_TERM,
    S_PASS_END, S_AVG_DIV, S_OUT
  } state_t;

endpackage

// ----- hdl/ppp_if.sv -----
// ----------------------------------------------------------------------------
// ppp_if
// Valid/ready channels for probe requests and probe results.
// ----------------------------------------------------------------------------
interface ppp_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               first_particle;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pressure_in;

  modport source (output valid, req_type, first_particle, pos_x, pos_y, pressure_in,
                  input ready);
  modport sink (input valid, req_type, first_particle, pos_x, pos_y, pressure_in,
                output ready);
endinterface

interface ppp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] probe_pressure;
  logic [1:0]         status;
  logic [10:0]        neighbor_count;
  logic               frame_truncated;

  modport source (output valid, probe_pressure, status, neighbor_count, frame_truncated,
                  input ready);
  modport sink (input valid, probe_pressure, status, neighbor_count, frame_truncated,
                output ready);
endinterface

// ----- hdl/ppp_unit.sv -----
// ----------------------------------------------------------------------------
// ppp_unit
// Shared iterative unit: Q.32 restoring divide (64 steps) and integer
// square root (32 steps).
// ----------------------------------------------------------------------------
module ppp_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  ppp_pkg::ureq_t   req,
  input  logic [63:0]      opa,
  input  logic [63:0]      opb,
  input  logic [63:0]      opd,
  output ppp_pkg::uresp_t  resp,
  output logic [63:0]      result
);
  import ppp_pkg::*;

  logic        busy_r, done_r;
  umode_t      mode_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, lo_r, d_r, q_r;

  logic [64:0] rem65, div_sub;
  logic        div_ge;
  logic [63:0] sq_t;
  logic        sq_ge;

  always_comb begin
    rem65   = {rem_r, lo_r[63]};
    div_ge  = rem65 >= {1'b0, d_r};
    div_sub = rem65 - {1'b0, d_r};
    sq_t    = q_r + lo_r;
    sq_ge   = rem_r >= sq_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        if (req.mode == UM_DIV && opa >= opd) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      mode_r <= req.mode;
      d_r    <= opd;
      rem_r  <= opa;
      unique case (req.mode)
        UM_DIV: begin
          lo_r  <= opb;
          q_r   <= '1;
          cnt_r <= 6'd63;
        end
        UM_SQRT: begin
          lo_r  <= 64'h4000_0000_0000_0000;
          q_r   <= '0;
          cnt_r <= 6'd31;
        end
      endcase
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      unique case (mode_r)
        UM_DIV: begin
          lo_r  <= lo_r << 1;
          rem_r <= div_ge ? div_sub[63:0] : rem65[63:0];
          q_r   <= {q_r[62:0], div_ge};
        end
        UM_SQRT: begin
          if (sq_ge) begin
            rem_r <= rem_r - sq_t;
            q_r   <= (q_r >> 1) + lo_r;
          end else begin
            q_r <= q_r >> 1;
          end
          lo_r <= lo_r >> 2;
        end
      endcase
    end
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign result    = q_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("unit done while busy");
  a_sqrt_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && mode_r == UM_SQRT |-> q_r[63:32] == 32'd0)
    else $error("root wider than 32 bits");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && req.start |=> busy_r || done_r)
    else $error("start not taken");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == 6'd0 |=> done_r && !busy_r)
    else $error("unit did not finish");

endmodule

// ----- hdl/particle_probe_pressure.sv -----
// ----------------------------------------------------------------------------
// particle_probe_pressure
// Particle store with pressure probes: average, nearest or MPS Taylor estimate.
// ----------------------------------------------------------------------------
// Loads produce no result. A probe scans the stored particles; average then
// divides the sum by the count, and MPS adds a weight pass and a gradient pass
// over the anchor's neighbors. The shared divide/root unit and the single 32x32
// multiplier serve all of these steps.
// Result is registered; the next item is taken while it waits.
// Synchronous reset clears the store count, truncation flag, state, output
// valid flag and configuration; store and datapath contents are not cleared.
// ----------------------------------------------------------------------------
module particle_probe_pressure #(
  parameter int MAX_PARTICLES = ppp_pkg::MAX_PARTICLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppp_in_if.sink                       in_ch,
  ppp_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ppp_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [ppp_pkg::CFG_DW-1:0]   cfg_data
);
  import ppp_pkg::*;

  localparam int AW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW   = $clog2(MAX_PARTICLES + 1);
  localparam int SUMW = 32 + CW;
  localparam int CXW  = (CW > 11) ? CW : 11;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTICLES);
  localparam logic signed [63:0] LIM62 = 64'sh4000_0000_0000_0000;
  localparam logic [63:0] LIM61 = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] P32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] P32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] p;
  } particle_t;

  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] s1, s2;
    s1 = {a[31], a} - {b[31], b};
    s2 = {b[31], b} - {a[31], a};
    abs_diff = (a < b) ? {1'b1, s2[31:0]} : {1'b0, s1[31:0]};
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? '1 : s[63:0];
  endfunction

  // configuration
  logic [1:0]  method_r;
  logic [30:0] radius_r;
  logic [10:0] minnb_r;

  // control
  state_t        state_r, state_nxt;
  logic [CW-1:0] pcount_r;
  logic          trunc_r;
  logic          out_valid_r;

  // datapath
  particle_t          mem_r [MAX_PARTICLES];
  particle_t          rd_r, anc_r;
  logic signed [31:0] px_r, py_r, refx_r, refy_r;
  logic [61:0]        rsq_r;
  logic [CW-1:0]      idx_r, cnt_all_r, cnt_nz_r;
  logic [1:0]         pass_r;
  logic [31:0]        dxm_r, dym_r, rxm_r, rym_r, dpm_r, r_r;
  logic               dx_neg_r, dy_neg_r, rx_neg_r, ry_neg_r, dp_neg_r, dot_neg_r;
  logic [63:0]        prod_r, sx_r, ds_r, best_r, n0_r, w_r, p1_r, dotm_r, y_r;
  logic [63:0]        ma_r, mb_r;
  logic [127:0]       macc_r;
  logic [1:0]         kq_r;
  mq_ret_t            mq_ret_r;
  logic signed [SUMW-1:0] sum_r;
  logic               found_r;
  logic signed [63:0] acc_r, res_p_r;
  logic [1:0]         res_st_r;
  logic [CW-1:0]      res_cnt_r;
  logic signed [31:0] out_p_r;
  logic [1:0]         out_st_r;
  logic [10:0]        out_cnt_r;
  logic               out_tr_r;

  // combinational
  logic        in_fire, is_load, mem_we, out_free;
  logic [AW-1:0] waddr;
  logic        is_avg, is_near, is_mps, in_rad, nz, mps_fail, w_skip;
  logic [31:0] mul_a, mul_b;
  ureq_t       u_req;
  uresp_t      u_resp;
  logic [63:0] u_a, u_b, u_d, u_res;
  logic [127:0] mq_pp;
  logic [63:0] mq_res;
  logic        sum_neg;
  logic [SUMW-1:0] sum_mag;
  logic [63:0] term;
  logic signed [63:0] acc_sum;
  logic [CXW-1:0] cnt_x;

  ppp_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (u_req),
    .opa    (u_a),
    .opb    (u_b),
    .opd    (u_d),
    .resp   (u_resp),
    .result (u_res)
  );

  always_comb begin
    in_fire  = in_ch.valid && (state_r == S_IDLE);
    is_load  = in_ch.req_type == REQ_LOAD;
    mem_we   = in_fire && is_load && (in_ch.first_particle || pcount_r != MAX_CNT);
    waddr    = in_ch.first_particle ? '0 : pcount_r[AW-1:0];
    out_free = !out_valid_r || out_ch.ready;
    is_avg   = method_r == METHOD_AVG;
    is_near  = method_r == METHOD_NEAR;
    is_mps   = !is_avg && !is_near;
    in_rad   = ds_r <= {2'b00, rsq_r};
    nz       = ds_r != 64'd0;
    mps_fail = (pcount_r == '0) || (radius_r == '0) || !found_r ||
               (CXW'(cnt_nz_r) < CXW'(minnb_r));
    w_skip   = (u_res == 64'd0) || (u_res >= {33'd0, radius_r});
    unique case (kq_r)
      2'd0:       mq_pp = {64'd0, prod_r};
      2'd1, 2'd2: mq_pp = {32'd0, prod_r, 32'd0};
      default:    mq_pp = {prod_r, 64'd0};
    endcase
    mq_res   = (macc_r[127:96] != 32'd0) ? '1 : macc_r[95:32];
    sum_neg  = sum_r[SUMW-1];
    sum_mag  = sum_neg ? SUMW'(-sum_r) : SUMW'(sum_r);
    term     = ((y_r > LIM61) ? LIM61 : y_r) << 1;
    acc_sum  = (dot_neg_r ^ dp_neg_r) ? acc_r - $signed(term) : acc_r + $signed(term);
    cnt_x    = CXW'(res_cnt_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_fire && !is_load) state_nxt = S_RSQ;
      S_RSQ:     state_nxt = S_RSQ_W;
      S_RSQ_W:   state_nxt = S_RD;
      S_RD:      state_nxt = (idx_r == pcount_r) ? S_PASS_END : S_DIFF;
      S_DIFF:    state_nxt = S_SQX;
      S_SQX:     state_nxt = S_SQY;
      S_SQY:     state_nxt = S_DSUM;
      S_DSUM:    state_nxt = S_EVAL;
      S_EVAL:    state_nxt = (pass_r != 2'd0 && in_rad && nz) ? S_W_SQRT : S_RD;
      S_W_SQRT:  if (u_resp.done) state_nxt = w_skip ? S_W_ACC : S_W_DIV;
      S_W_DIV:   if (u_resp.done) state_nxt = S_MQ_MUL;
      S_MQ_MUL:  state_nxt = S_MQ_ACC;
      S_MQ_ACC:  state_nxt = (kq_r == 2'd3) ? S_MQ_END : S_MQ_MUL;
      S_MQ_END: begin
        unique case (mq_ret_r)
          MQ_W:    state_nxt = S_W_ACC;
          MQ_X:    state_nxt = S_MQ_MUL;
          default: state_nxt = S_TERM;
        endcase
      end
      S_W_ACC:   state_nxt = (pass_r == 2'd2 && w_r != 64'd0) ? S_DOT_X : S_RD;
      S_DOT_X:   state_nxt = S_DOT_Y;
      S_DOT_Y:   state_nxt = S_DOT_SUM;
      S_DOT_SUM: state_nxt = S_FRAC;
      S_FRAC:    if (u_resp.done) state_nxt = S_C;
      S_C:       if (u_resp.done) state_nxt = S_MQ_MUL;
      S_TERM:    state_nxt = S_RD;
      S_PASS_END: begin
        priority if (pass_r == 2'd0) begin
          if (is_avg) state_nxt = (cnt_all_r == '0) ? S_OUT : S_AVG_DIV;
          else if (is_near || mps_fail) state_nxt = S_OUT;
          else state_nxt = S_RD;
        end else if (pass_r == 2'd1) begin
          state_nxt = (n0_r == 64'd0) ? S_OUT : S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_AVG_DIV: if (u_resp.done) state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // shared unit and multiplier control
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    u_req.start = 1'b0;
    u_req.mode = UM_DIV;
    u_a        = '0;
    u_b        = '0;
    u_d        = '0;
    unique case (state_r)
      S_RSQ: begin
        mul_a = {1'b0, radius_r};
        mul_b = {1'b0, radius_r};
      end
      S_SQX: begin
        mul_a = dxm_r;
        mul_b = dxm_r;
      end
      S_SQY: begin
        mul_a = dym_r;
        mul_b = dym_r;
      end
      S_DOT_X: begin
        mul_a = dxm_r;
        mul_b = rxm_r;
      end
      S_DOT_Y: begin
        mul_a = dym_r;
        mul_b = rym_r;
      end
      S_MQ_MUL: begin
        mul_a = kq_r[1] ? ma_r[63:32] : ma_r[31:0];
        mul_b = kq_r[0] ? mb_r[63:32] : mb_r[31:0];
      end
      S_W_SQRT: begin
        u_req.mode = UM_SQRT;
        u_a = ds_r;
      end
      S_W_DIV: begin
        u_b = {1'b0, radius_r, 32'd0};
        u_d = {32'd0, r_r};
      end
      S_FRAC: begin
        u_a = {32'd0, w_r[63:32]};
        u_b = {w_r[31:0], 32'd0};
        u_d = n0_r;
      end
      S_C: begin
        u_a = {32'd0, dotm_r[63:32]};
        u_b = {dotm_r[31:0], 32'd0};
        u_d = ds_r;
      end
      S_AVG_DIV: begin
        u_b = 64'(sum_mag);
        u_d = 64'(cnt_all_r);
      end
      default: ;
    endcase
    if (state_r == S_W_SQRT || state_r == S_W_DIV || state_r == S_FRAC ||
        state_r == S_C || state_r == S_AVG_DIV) begin
      u_req.start = !u_resp.busy && !u_resp.done;
    end
  end

  assign in_ch.ready            = state_r == S_IDLE;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.probe_pressure  = out_p_r;
  assign out_ch.status          = out_st_r;
  assign out_ch.neighbor_count  = out_cnt_r;
  assign out_ch.frame_truncated = out_tr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcount_r    <= '0;
      trunc_r     <= 1'b0;
      out_valid_r <= 1'b0;
      method_r    <= METHOD_RST;
      radius_r    <= RADIUS_RST;
      minnb_r     <= MIN_NB_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_addr == CFG_METHOD) method_r <= cfg_data[1:0];
        if (cfg_addr == CFG_RADIUS) radius_r <= cfg_data;
        if (cfg_addr == CFG_MIN_NB) minnb_r  <= cfg_data[10:0];
      end
      if (in_fire && is_load) begin
        if (in_ch.first_particle) begin
          pcount_r <= CW'(1);
          trunc_r  <= 1'b0;
        end else if (pcount_r == MAX_CNT) begin
          trunc_r <= 1'b1;
        end else begin
          pcount_r <= pcount_r + CW'(1);
        end
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[waddr] <= '{x: in_ch.pos_x, y: in_ch.pos_y, p: in_ch.pressure_in};
    if (state_r == S_RD) rd_r <= mem_r[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    unique case (state_r)
      S_IDLE: begin
        px_r      <= in_ch.pos_x;
        py_r      <= in_ch.pos_y;
        refx_r    <= in_ch.pos_x;
        refy_r    <= in_ch.pos_y;
        idx_r     <= '0;
        pass_r    <= 2'd0;
        cnt_all_r <= '0;
        cnt_nz_r  <= '0;
        sum_r     <= '0;
        found_r   <= 1'b0;
      end
      S_RSQ_W: rsq_r <= prod_r[61:0];
      S_DIFF: begin
        {dx_neg_r, dxm_r} <= abs_diff(rd_r.x, refx_r);
        {dy_neg_r, dym_r} <= abs_diff(rd_r.y, refy_r);
        idx_r <= idx_r + CW'(1);
      end
      S_SQY:  sx_r <= prod_r;
      S_DSUM: ds_r <= sat_add(sx_r, prod_r);
      S_EVAL: begin
        if (pass_r == 2'd0 && in_rad) begin
          cnt_all_r <= cnt_all_r + CW'(1);
          if (nz) cnt_nz_r <= cnt_nz_r + CW'(1);
          sum_r <= sum_r + SUMW'(rd_r.p);
          if (!found_r || ds_r < best_r) begin
            best_r  <= ds_r;
            anc_r   <= rd_r;
            found_r <= 1'b1;
          end
        end
      end
      S_W_SQRT: begin
        r_r <= u_res[31:0];
        w_r <= '0;
      end
      S_W_DIV: begin
        ma_r     <= u_res - 64'h1_0000_0000;
        mb_r     <= u_res - 64'h1_0000_0000;
        kq_r     <= 2'd0;
        macc_r   <= '0;
        mq_ret_r <= MQ_W;
      end
      S_MQ_ACC: begin
        macc_r <= macc_r + mq_pp;
        kq_r   <= kq_r + 2'd1;
      end
      S_MQ_END: begin
        unique case (mq_ret_r)
          MQ_W: w_r <= mq_res;
          MQ_X: begin
            ma_r     <= mq_res;
            mb_r     <= {32'd0, dpm_r};
            kq_r     <= 2'd0;
            macc_r   <= '0;
            mq_ret_r <= MQ_Y;
          end
          default: y_r <= mq_res;
        endcase
      end
      S_W_ACC: if (pass_r == 2'd1) n0_r <= sat_add(n0_r, w_r);
      S_DOT_X: {dp_neg_r, dpm_r} <= abs_diff(rd_r.p, anc_r.p);
      S_DOT_Y: p1_r <= prod_r;
      S_DOT_SUM: begin
        if ((dx_neg_r ^ rx_neg_r) == (dy_neg_r ^ ry_neg_r)) begin
          dotm_r    <= p1_r + prod_r;
          dot_neg_r <= dx_neg_r ^ rx_neg_r;
        end else if (p1_r >= prod_r) begin
          dotm_r    <= p1_r - prod_r;
          dot_neg_r <= dx_neg_r ^ rx_neg_r;
        end else begin
          dotm_r    <= prod_r - p1_r;
          dot_neg_r <= dy_neg_r ^ ry_neg_r;
        end
      end
      S_FRAC: ma_r <= u_res;
      S_C: begin
        mb_r     <= u_res;
        kq_r     <= 2'd0;
        macc_r   <= '0;
        mq_ret_r <= MQ_X;
      end
      S_TERM: begin
        if (acc_sum > LIM62) acc_r <= LIM62;
        else if (acc_sum < -LIM62) acc_r <= -LIM62;
        else acc_r <= acc_sum;
      end
      S_PASS_END: begin
        priority if (pass_r == 2'd0) begin
          res_cnt_r <= is_mps ? cnt_nz_r : cnt_all_r;
          res_st_r  <= ST_NONE;
          res_p_r   <= '0;
          if (is_near && found_r) begin
            res_p_r  <= 64'(anc_r.p);
            res_st_r <= ST_OK;
          end
          if (is_mps && !mps_fail) begin
            pass_r <= 2'd1;
            idx_r  <= '0;
            refx_r <= anc_r.x;
            refy_r <= anc_r.y;
            n0_r   <= '0;
          end
        end else if (pass_r == 2'd1) begin
          if (n0_r == 64'd0) begin
            res_p_r  <= 64'(anc_r.p);
            res_st_r <= ST_ANCHOR;
          end else begin
            pass_r <= 2'd2;
            idx_r  <= '0;
            acc_r  <= '0;
            {rx_neg_r, rxm_r} <= abs_diff(px_r, anc_r.x);
            {ry_neg_r, rym_r} <= abs_diff(py_r, anc_r.y);
          end
        end else begin
          res_p_r  <= 64'(anc_r.p) + acc_r;
          res_st_r <= ST_OK;
        end
      end
      S_AVG_DIV: begin
        res_p_r  <= sum_neg ? -$signed(u_res) : $signed(u_res);
        res_st_r <= ST_OK;
      end
      S_OUT: begin
        if (out_free) begin
          if (res_p_r > P32_MAX) out_p_r <= P32_MAX[31:0];
          else if (res_p_r < P32_MIN) out_p_r <= P32_MIN[31:0];
          else out_p_r <= res_p_r[31:0];
          out_st_r  <= res_st_r;
          out_cnt_r <= (cnt_x > CXW'(2047)) ? 11'h7FF : cnt_x[10:0];
          out_tr_r  <= trunc_r;
        end
      end
      default: ;
    endcase
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n) pcount_r <= MAX_CNT)
    else $error("store count beyond capacity");
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    trunc_r |-> pcount_r == MAX_CNT)
    else $error("truncation flagged with room left");
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIFF |-> idx_r < pcount_r)
    else $error("read beyond stored particles");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result item not presented");

endmodule

// ----- sim/particle_probe_pressure_tb.sv -----
// ----------------------------------------------------------------------------
// particle_probe_pressure_tb
// Self-checking bench for the particle probe pressure block. Loads particle
// frames and issues probes under every method and several register settings,
// including store overflow. A fixed-point estimator predicts each probe result
// and a scoreboard compares the results in order.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [31:0] pressure;
  logic [1:0]         status;
  logic [10:0]        nb_count;
  logic               truncated;
} probe_result_t;

class pressure_scoreboard;
  localparam int DEPTH = ppp_pkg::MAX_PARTICLES_DEF;
  localparam bit [63:0] ALL1 = ~64'd0;
  localparam longint LIM62 = longint'(1) << 62;

  bit [1:0]      method;
  bit [30:0]     radius;
  bit [10:0]     min_nb;
  longint        px_mem[DEPTH];
  longint        py_mem[DEPTH];
  longint        pr_mem[DEPTH];
  int unsigned   n_stored;
  bit            trunc;
  probe_result_t expected_q[$];
  int            errors;
  int            n_probes;
  int            n_loads;
  int            n_checked;

  function void clear();
    method   = ppp_pkg::METHOD_RST;
    radius   = ppp_pkg::RADIUS_RST;
    min_nb   = ppp_pkg::MIN_NB_RST;
    n_stored = 0;
    trunc    = 0;
  endfunction

  function void write_reg(logic [1:0] addr, logic [30:0] data);
    case (addr)
      ppp_pkg::CFG_METHOD: method = data[1:0];
      ppp_pkg::CFG_RADIUS: radius = data;
      ppp_pkg::CFG_MIN_NB: min_nb = data[10:0];
      default: ;
    endcase
  endfunction

  function bit [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function bit [63:0] dist2(longint dx, longint dy);
    bit [63:0] ax, ay, sx, sy;
    ax = mag(dx);
    ay = mag(dy);
    sx = ax * ax;
    sy = ay * ay;
    return (sx > ALL1 - sy) ? ALL1 : sx + sy;
  endfunction

  function bit [63:0] root(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function bit [63:0] mul_fx(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) return ALL1;
    return p[95:32];
  endfunction

  function bit [63:0] div_fx(bit [63:0] n, bit [63:0] d);
    bit [127:0] q;
    if ((n >> 32) >= d) return ALL1;
    q = {32'd0, n, 32'd0} / {64'd0, d};
    return q[63:0];
  endfunction

  function bit [63:0] weight(bit [63:0] ds);
    bit [63:0] r, q, t, re;
    r = root(ds);
    re = radius;
    if (r == 0 || r >= re) return 0;
    q = (re << 32) / r;
    t = q - (64'd1 << 32);
    return mul_fx(t, t);
  endfunction

  function longint clamp62(longint v);
    if (v > LIM62) return LIM62;
    if (v < -LIM62) return -LIM62;
    return v;
  endfunction

  function bit nearest(longint x, longint y, bit [63:0] rsq,
                       output int unsigned idx, output int unsigned cnt);
    bit [63:0] best, ds;
    bit found;
    best = ALL1;
    found = 0;
    idx = 0;
    cnt = 0;
    for (int unsigned i = 0; i < n_stored; i++) begin
      ds = dist2(px_mem[i] - x, py_mem[i] - y);
      if (ds <= rsq) begin
        cnt++;
        if (!found || ds < best) begin
          best = ds;
          idx = i;
          found = 1;
        end
      end
    end
    return found;
  endfunction

  function void estimate_mps(longint x, longint y, bit [63:0] rsq,
                             output longint p, output bit [1:0] st,
                             output int unsigned cnt);
    int unsigned a, unused;
    longint ax, ay, pa, rx, ry, acc, dx, dy, dot, dp, term;
    bit [63:0] n0, ds, w, frac, c, xq, yq;
    p = 0;
    st = ppp_pkg::ST_NONE;
    cnt = 0;
    acc = 0;
    n0 = 0;
    for (int unsigned i = 0; i < n_stored; i++) begin
      ds = dist2(px_mem[i] - x, py_mem[i] - y);
      if (ds != 0 && ds <= rsq) cnt++;
    end
    if (n_stored == 0 || radius == 0 || cnt < min_nb) return;
    if (!nearest(x, y, rsq, a, unused)) return;
    ax = px_mem[a];
    ay = py_mem[a];
    pa = pr_mem[a];
    for (int unsigned i = 0; i < n_stored; i++) begin
      ds = dist2(px_mem[i] - ax, py_mem[i] - ay);
      if (ds != 0 && ds <= rsq) begin
        w = weight(ds);
        n0 = (n0 > ALL1 - w) ? ALL1 : n0 + w;
      end
    end
    if (n0 == 0) begin
      p = pa;
      st = ppp_pkg::ST_ANCHOR;
      return;
    end
    rx = x - ax;
    ry = y - ay;
    for (int unsigned i = 0; i < n_stored; i++) begin
      dx = px_mem[i] - ax;
      dy = py_mem[i] - ay;
      ds = dist2(dx, dy);
      if (ds != 0 && ds <= rsq) begin
        w = weight(ds);
        if (w != 0) begin
          dot = dx * rx + dy * ry;
          dp = pr_mem[i] - pa;
          frac = div_fx(w, n0);
          c = div_fx(mag(dot), ds);
          xq = mul_fx(frac, c);
          yq = mul_fx(xq, mag(dp));
          if (yq > 64'(LIM62 / 2)) yq = 64'(LIM62 / 2);
          term = longint'(yq * 2);
          if ((dot < 0) != (dp < 0)) term = -term;
          acc = clamp62(acc + term);
        end
      end
    end
    p = pa + acc;
    st = ppp_pkg::ST_OK;
  endfunction

  function probe_result_t estimate(longint x, longint y);
    probe_result_t r;
    bit [63:0] rsq;
    longint p, sum;
    bit [1:0] st;
    int unsigned cnt, idx;
    rsq = 64'(radius) * 64'(radius);
    p = 0;
    st = ppp_pkg::ST_NONE;
    cnt = 0;
    if (method == ppp_pkg::METHOD_AVG) begin
      sum = 0;
      for (int unsigned i = 0; i < n_stored; i++) begin
        if (dist2(px_mem[i] - x, py_mem[i] - y) <= rsq) begin
          sum += pr_mem[i];
          cnt++;
        end
      end
      if (cnt != 0) begin
        p = sum / longint'(cnt);
        st = ppp_pkg::ST_OK;
      end
    end else if (method == ppp_pkg::METHOD_NEAR) begin
      if (nearest(x, y, rsq, idx, cnt)) begin
        p = pr_mem[idx];
        st = ppp_pkg::ST_OK;
      end
    end else begin
      estimate_mps(x, y, rsq, p, st, cnt);
    end
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    if (cnt > 2047) cnt = 2047;
    r.pressure  = p[31:0];
    r.status    = st;
    r.nb_count  = cnt[10:0];
    r.truncated = trunc;
    return r;
  endfunction

  function void note_input(bit req, bit first, logic [31:0] x, logic [31:0] y,
                           logic [31:0] pin);
    if (req == ppp_pkg::REQ_LOAD) begin
      n_loads++;
      if (first) begin
        n_stored = 0;
        trunc = 0;
      end
      if (n_stored < DEPTH) begin
        px_mem[n_stored] = longint'($signed(x));
        py_mem[n_stored] = longint'($signed(y));
        pr_mem[n_stored] = longint'($signed(pin));
        n_stored++;
      end else begin
        trunc = 1;
      end
    end else begin
      n_probes++;
      expected_q.push_back(estimate(longint'($signed(x)), longint'($signed(y))));
    end
  endfunction

  function void check_result(probe_result_t got);
    probe_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("probe result with nothing expected: pressure %0d", got.pressure);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    n_checked++;
    if (got.pressure !== exp_r.pressure) begin
      $error("probe_pressure: expected %0d, got %0d", exp_r.pressure, got.pressure);
      errors++;
    end
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.nb_count !== exp_r.nb_count) begin
      $error("neighbor_count: expected %0d, got %0d", exp_r.nb_count, got.nb_count);
      errors++;
    end
    if (got.truncated !== exp_r.truncated) begin
      $error("frame_truncated: expected %0d, got %0d", exp_r.truncated, got.truncated);
      errors++;
    end
  endfunction
endclass

module particle_probe_pressure_tb;
  import ppp_pkg::*;

  localparam int WD_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [30:0] cfg_data;

  ppp_in_if  in_ch();
  ppp_out_if out_ch();

  particle_probe_pressure u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  pressure_scoreboard sb = new();

  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  int  wd_count = 0;
  int  n_pressure_stalls = 0;
  logic [31:0] last_x, last_y;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: sample at the falling edge, check at the next rising edge
  initial begin
    probe_result_t got;
    bit hit;
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      hit = out_ch.valid && out_ch.ready;
      got.pressure  = out_ch.probe_pressure;
      got.status    = out_ch.status;
      got.nb_count  = out_ch.neighbor_count;
      got.truncated = out_ch.frame_truncated;
      @(posedge clk);
      if (hit) sb.check_result(got);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 599;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      wd_count <= 0;
    end else begin
      wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WD_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
    if (in_ch.valid && !in_ch.ready && !out_ch.ready) n_pressure_stalls <= n_pressure_stalls + 1;
  end

  task automatic send(bit req, bit first, logic [31:0] x, logic [31:0] y,
                      logic [31:0] pin);
    bit rdy;
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= req;
    in_ch.first_particle <= first;
    in_ch.pos_x          <= x;
    in_ch.pos_y          <= y;
    in_ch.pressure_in    <= pin;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    sb.note_input(req, first, x, y, pin);
    if (req == REQ_LOAD) begin
      last_x = x;
      last_y = y;
    end
  endtask

  task automatic load(bit first, logic [31:0] x, logic [31:0] y, logic [31:0] pin);
    send(REQ_LOAD, first, x, y, pin);
  endtask

  task automatic probe(logic [31:0] x, logic [31:0] y);
    send(REQ_PROBE, $urandom_range(0, 1), x, y, $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] addr, logic [30:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [1:0] m, logic [30:0] r, logic [10:0] mn);
    drain();
    set_reg(CFG_METHOD, {29'd0, m});
    set_reg(CFG_RADIUS, r);
    set_reg(CFG_MIN_NB, {20'd0, mn});
  endtask

  function automatic logic [31:0] jitter(logic [31:0] c, int unsigned span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  // one frame: a cluster of particles, then probes mostly inside it, with occasional further loads
  task automatic run_frame(int n_part, int n_probe);
    logic [31:0] cx, cy;
    int unsigned span;
    span = (sb.radius > 31'h0100_0000) ? 32'h0100_0000 : sb.radius;
    if (span == 0) span = 1;
    cx = $urandom;
    cy = $urandom;
    load(1'b1, jitter(cx, span), jitter(cy, span), $urandom);
    for (int i = 1; i < n_part; i++) begin
      if ($urandom_range(0, 5) == 0) load(1'b0, last_x, last_y + 1, $urandom);
      else load(1'b0, jitter(cx, span), jitter(cy, span), $urandom);
    end
    for (int i = 0; i < n_probe; i++) begin
      case ($urandom_range(0, 9))
        0:       probe($urandom, $urandom);
        1:       probe(last_x, last_y);
        2:       load(1'b0, jitter(cx, span), jitter(cy, span), $urandom);
        default: probe(jitter(cx, span), jitter(cy, span));
      endcase
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_addr             <= CFG_METHOD;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= REQ_LOAD;
    in_ch.first_particle <= 1'b0;
    in_ch.pos_x          <= '0;
    in_ch.pos_y          <= '0;
    in_ch.pressure_in    <= '0;
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, coincident particles, ties
    probe(32'd0, 32'd0);
    load(1'b1, 32'd0, 32'd0, 32'd100);
    load(1'b0, 32'd100000, 32'd0, 32'd200);
    load(1'b0, 32'd0, 32'd100000, 32'hFFFF_FED4);
    load(1'b0, 32'd0, 32'd0, 32'd50);
    load(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    probe(32'd10000, 32'd5000);
    probe(32'd0, 32'd0);
    probe(32'h7FFF_FFFF, 32'h8000_0000);
    probe(32'd50000, 32'd50000);
    setup(METHOD_AVG, 31'h7FFF_FFFF, 11'd1);
    probe(32'd0, 32'd0);
    probe(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    setup(METHOD_NEAR, 31'd335544, 11'd0);
    probe(32'd50000, 32'd50000);
    probe(32'd50000, 32'd0);
    // anchor whose only neighbor sits exactly on the radius
    setup(2'd3, 31'd335544, 11'd1);
    load(1'b1, 32'd0, 32'd0, 32'd10);
    load(1'b0, 32'd335544, 32'd0, 32'd20);
    probe(32'd1, 32'd0);
    setup(2'd2, 31'd0, 11'd0);
    probe(32'd0, 32'd0);
    setup(2'd2, 31'd335544, 11'd1024);
    probe(32'd1, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setup(2'd2, 31'd335544, 11'd3);
        1: setup(METHOD_AVG, 31'($urandom_range(1, 32'h0400_0000)), 11'd1);
        2: setup(METHOD_NEAR, 31'h0100_0000, 11'd1);
        3: setup(2'd3, 31'h7FFF_FFFF, 11'd0);
        4: setup(2'd2, 31'd1, 11'd1);
        default: setup(2'd2, 31'($urandom_range(32'h1_0000, 32'h0400_0000)),
                       11'($urandom_range(1, 4)));
      endcase
      idle_on = (ph != 3);
      if (ph == 2) begin
        run_frame(6, 0);
        drain();
        long_hold_req = 1'b1;
        for (int i = 0; i < 10; i++) probe(jitter(last_x, 1000), jitter(last_y, 1000));
      end
      run_frame($urandom_range(3, 12), 18);
    end

    // overflow the store
    setup(METHOD_NEAR, 31'd1000, 11'd1);
    idle_on = 1'b0;
    for (int i = 0; i < 1030; i++) load(i == 0, $urandom, $urandom, $urandom);
    probe(last_x, last_y);
    probe(last_x + 500, last_y);
    setup(METHOD_AVG, 31'd1000, 11'd1);
    probe(last_x, last_y);
    setup(2'd2, 31'd1, 11'd1024);
    probe(last_x, last_y);

    // last part: no idling on either side
    setup($urandom_range(0, 3), 31'd335544, 11'd2);
    run_frame(8, 20);

    drain();
    repeat (100) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d probe results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("Covered %0d loads and %0d probes (%0d results checked) over all methods,",
             sb.n_loads, sb.n_probes, sb.n_checked);
    $display("radius and neighbor extremes, store overflow and %0d back-pressure cycles.",
             n_pressure_stalls);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/ppp_pkg.sv
hdl/ppp_if.sv
hdl/ppp_unit.sv
hdl/particle_probe_pressure.sv
sim/particle_probe_pressure_tb.sv
